// ===== src/rfc_pkg.sv =====
// Package for the reciprocal frequency counter: widths, reset values, phase and
// back-end state encodings, and the measurement record passed from front to back.
// No dependencies.
package rfc_pkg;

   localparam int REG_W        = 32;
   localparam int FREQ_W       = 42;
   localparam int SCALE_W      = 10;
   localparam int PROD_W       = 2 * REG_W;
   localparam int NUM_W        = PROD_W + SCALE_W;
   localparam int CSR_ADDR_W   = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam logic [SCALE_W-1:0] MILLI_SCALE   = 10'd1000;
   localparam logic [REG_W-1:0]   GATE_RESET    = 32'd84000000;
   localparam logic [REG_W-1:0]   REF_HZ_RESET  = 32'd84001168;

   localparam logic [0:0] CSR_IDX_GATE = 1'd0;
   localparam logic [0:0] CSR_IDX_REF  = 1'd1;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_OPEN,
      PHASE_COUNT,
      PHASE_CLOSED
   } rfc_phase_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_MUL,
      BE_SCALE,
      BE_CHECK,
      BE_DIV,
      BE_OUT
   } rfc_back_state_type;

   typedef struct packed {
      logic [REG_W-1:0] period;
      logic [REG_W-1:0] elapsed;
      logic             ovf;
   } rfc_entry_type;

endpackage

// ===== src/reciprocal_frequency_counter.sv =====
// Reciprocal (equal-precision) frequency counter. Each req transaction is one
// reference-clock tick with a flag for a measured-signal edge; the front end takes
// one tick every clock cycle unless req_stall is high. An edge opens a gate of
// gate_period_ticks ticks, the next edge starts timing, edges are counted while the
// gate is open, and the first edge after the gate closes ends the measurement. One
// rsp transaction then reports periods * ref_frequency_hz * 1000 / elapsed in
// millihertz, rounded down, with the period and tick counts; overflowed flags
// saturated or clamped counters and a clamped frequency. A finished measurement
// waits in a two-entry queue while the back end works it out: it takes the
// measurement, does the 32x32 multiply, scales by 1000, checks the range and runs a
// one-bit-per-cycle division (a zero count or a clamped frequency skips the
// division), then holds the result until taken. req_stall rises only when both
// queue entries are full. Registers: gate_period_ticks at byte 0, ref_frequency_hz
// at byte 4; write them only while no measurement is pending.
// Depends on rfc_pkg, rfc_front, rfc_queue and rfc_back.
module reciprocal_frequency_counter
   import rfc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Tick channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_signal_edge,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FREQ_W-1:0]      rsp_frequency_millihertz,
   output logic [REG_W-1:0]       rsp_period_count,
   output logic [REG_W-1:0]       rsp_elapsed_ticks,
   output logic                   rsp_overflowed,
   // Register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [REG_W-1:0]       pwdata,
   output logic [REG_W-1:0]       prdata,
   output logic                   pready
);

   logic [REG_W-1:0]  gate_ff, gate_in;
   logic [REG_W-1:0]  ref_hz_ff, ref_hz_in;
   logic              csr_write;
   logic              accept;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_not_empty;
   rfc_entry_type     push_entry;
   rfc_entry_type     head_entry;

   // Register port: zero wait states, register picked by address bit 2.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      gate_in   = gate_ff;
      ref_hz_in = ref_hz_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_IDX_GATE: gate_in   = pwdata;
            CSR_IDX_REF:  ref_hz_in = pwdata;
            default: begin
               gate_in = gate_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_GATE: prdata = gate_ff;
         CSR_IDX_REF:  prdata = ref_hz_ff;
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff   <= GATE_RESET;
         ref_hz_ff <= REF_HZ_RESET;
      end else begin
         gate_ff   <= gate_in;
         ref_hz_ff <= ref_hz_in;
      end
   end

   // Hold off ticks only when no queue slot is left for an ending edge.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   rfc_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .signal_edge       (req_signal_edge),
      .gate_period_ticks (gate_ff),
      .push              (push),
      .entry             (push_entry)
   );

   rfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head_entry)
   );

   rfc_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .entry_valid              (q_not_empty),
      .entry                    (head_entry),
      .pop                      (pop),
      .ref_frequency_hz         (ref_hz_ff),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_frequency_millihertz (rsp_frequency_millihertz),
      .rsp_period_count         (rsp_period_count),
      .rsp_elapsed_ticks        (rsp_elapsed_ticks),
      .rsp_overflowed           (rsp_overflowed)
   );

endmodule

// ===== src/rfc_front.sv =====
// Front end of the reciprocal frequency counter: gate, edge and timing counters
// and the four-phase measurement sequencer. Depends on rfc_pkg.
module rfc_front
   import rfc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                signal_edge,
   input  logic [REG_W-1:0]    gate_period_ticks,
   output logic                push,
   output rfc_entry_type       entry
);

   localparam int WIDE_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
   localparam logic [WIDE_W-1:0] REG_MAX_WIDE = WIDE_W'({REG_W{1'b1}});

   rfc_phase_type           phase_ff, phase_in, phase_mid;
   logic [REG_W-1:0]        gate_ff, gate_in;
   logic [COUNT_WIDTH-1:0]  edges_ff, edges_in;
   logic [COUNT_WIDTH-1:0]  timing_ff, timing_in, timing_mid;
   logic                    sat_ff, sat_in, sat_mid;
   logic [REG_W:0]          p_clamp, e_clamp;

   // Clamp a count to the report width; top bit flags the clamp.
   function automatic logic [REG_W:0] clamp_count(input logic [COUNT_WIDTH-1:0] v);
      logic [WIDE_W-1:0] wide;
      logic [REG_W:0]    res;
      wide = WIDE_W'(v);
      if (wide > REG_MAX_WIDE) begin
         res = {1'b1, {REG_W{1'b1}}};
      end else begin
         res = {1'b0, wide[REG_W-1:0]};
      end
      return res;
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      phase_mid  = phase_ff;
      gate_in    = gate_ff;
      edges_in   = edges_ff;
      timing_mid = timing_ff;
      sat_mid    = sat_ff;
      push       = 1'b0;

      if (accept) begin
         // Advance the gate first; it may close within this tick.
         if (phase_ff == PHASE_OPEN || phase_ff == PHASE_COUNT) begin
            if (gate_ff != {REG_W{1'b1}}) begin
               gate_in = gate_ff + 1'b1;
            end
            if (gate_in >= gate_period_ticks) begin
               phase_mid = PHASE_CLOSED;
            end
         end
         // Timing runs once the first counted edge is seen.
         if ((phase_mid == PHASE_COUNT || phase_mid == PHASE_CLOSED) && edges_ff != '0) begin
            if (timing_ff == {COUNT_WIDTH{1'b1}}) begin
               sat_mid = 1'b1;
            end else begin
               timing_mid = timing_ff + 1'b1;
            end
         end
         phase_in = phase_mid;
      end

      timing_in = timing_mid;
      sat_in    = sat_mid;

      if (accept && signal_edge) begin
         case (phase_mid)
            PHASE_IDLE: begin
               gate_in   = '0;
               edges_in  = '0;
               timing_in = '0;
               sat_in    = 1'b0;
               phase_in  = PHASE_OPEN;
            end
            PHASE_OPEN: begin
               edges_in  = COUNT_WIDTH'(1);
               timing_in = '0;
               phase_in  = PHASE_COUNT;
            end
            PHASE_COUNT: begin
               if (edges_ff == {COUNT_WIDTH{1'b1}}) begin
                  sat_in = 1'b1;
               end else begin
                  edges_in = edges_ff + 1'b1;
               end
            end
            PHASE_CLOSED: begin
               push      = 1'b1;
               gate_in   = '0;
               edges_in  = '0;
               timing_in = '0;
               sat_in    = 1'b0;
               phase_in  = PHASE_IDLE;
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

   // Measurement record for the ending edge.
   always_comb begin
      p_clamp = clamp_count(edges_ff);
      e_clamp = clamp_count(timing_mid);
      if (edges_ff != '0) begin
         entry.period  = p_clamp[REG_W-1:0];
         entry.elapsed = e_clamp[REG_W-1:0];
         entry.ovf     = sat_mid | p_clamp[REG_W] | e_clamp[REG_W];
      end else begin
         entry.period  = '0;
         entry.elapsed = '0;
         entry.ovf     = sat_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         gate_ff   <= '0;
         edges_ff  <= '0;
         timing_ff <= '0;
         sat_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         gate_ff   <= gate_in;
         edges_ff  <= edges_in;
         timing_ff <= timing_in;
         sat_ff    <= sat_in;
      end
   end

endmodule

// ===== src/rfc_queue.sv =====
// Short queue of finished measurements between front and back end of the
// reciprocal frequency counter. Depends on rfc_pkg.
module rfc_queue
   import rfc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rfc_entry_type  push_entry,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output rfc_entry_type  head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rfc_entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/rfc_back.sv =====
// Back end of the reciprocal frequency counter: multiply, scale to millihertz,
// bit-serial divide and hold the result until taken. Depends on rfc_pkg.
module rfc_back
   import rfc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_valid,
   input  rfc_entry_type       entry,
   output logic                pop,
   input  logic [REG_W-1:0]    ref_frequency_hz,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FREQ_W-1:0]   rsp_frequency_millihertz,
   output logic [REG_W-1:0]    rsp_period_count,
   output logic [REG_W-1:0]    rsp_elapsed_ticks,
   output logic                rsp_overflowed
);

   localparam int TOP_W = NUM_W - FREQ_W;
   localparam int DCNT_W = $clog2(FREQ_W);

   rfc_back_state_type   state_ff, state_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [REG_W-1:0]     p_ff, p_in;
   logic [REG_W-1:0]     e_ff, e_in;
   logic                 ovf_ff, ovf_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [TOP_W-1:0]     rem_ff, rem_in;
   logic [FREQ_W-1:0]    low_ff, low_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [TOP_W:0]       trial;
   logic                 qbit;

   always_comb begin
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      p_in     = p_ff;
      e_in     = e_ff;
      ovf_in   = ovf_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      freq_in  = freq_ff;
      pop      = 1'b0;
      trial    = {rem_ff, low_ff[FREQ_W-1]};
      qbit     = 1'b0;

      case (state_ff)
         BE_IDLE: begin
            if (entry_valid) begin
               pop      = 1'b1;
               p_in     = entry.period;
               e_in     = entry.elapsed;
               ovf_in   = entry.ovf;
               state_in = BE_MUL;
            end
         end
         BE_MUL: begin
            prod_in  = PROD_W'(p_ff) * PROD_W'(ref_frequency_hz);
            state_in = BE_SCALE;
         end
         BE_SCALE: begin
            num_in   = NUM_W'(prod_ff) * NUM_W'(MILLI_SCALE);
            state_in = BE_CHECK;
         end
         BE_CHECK: begin
            // Quotient fits the field only if the top slice is below the divisor.
            if (p_ff == '0 || e_ff == '0) begin
               freq_in  = '0;
               state_in = BE_OUT;
            end else if (num_ff[NUM_W-1:FREQ_W] >= e_ff) begin
               freq_in  = {FREQ_W{1'b1}};
               ovf_in   = 1'b1;
               state_in = BE_OUT;
            end else begin
               rem_in   = num_ff[NUM_W-1:FREQ_W];
               low_in   = num_ff[FREQ_W-1:0];
               dcnt_in  = DCNT_W'(FREQ_W - 1);
               state_in = BE_DIV;
            end
         end
         BE_DIV: begin
            if (trial >= {1'b0, e_ff}) begin
               rem_in = TOP_W'(trial - {1'b0, e_ff});
               qbit   = 1'b1;
            end else begin
               rem_in = TOP_W'(trial);
            end
            low_in = {low_ff[FREQ_W-2:0], qbit};
            if (dcnt_ff == '0) begin
               freq_in  = low_in;
               state_in = BE_OUT;
            end else begin
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         BE_OUT: begin
            if (!rsp_stall) begin
               state_in = BE_IDLE;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   assign rsp_valid                = (state_ff == BE_OUT);
   assign rsp_frequency_millihertz = freq_ff;
   assign rsp_period_count         = p_ff;
   assign rsp_elapsed_ticks        = e_ff;
   assign rsp_overflowed           = ovf_ff;

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      e_ff    <= e_in;
      ovf_ff  <= ovf_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      freq_ff <= freq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule
